[rtl/core/spd_pkg.sv]
package spd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_OFS   = 3'd4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DEN   = 2'd1;
    localparam logic [1:0] STAT_PLANE = 2'd2;

    localparam logic [31:0] LIM_NEG  = 32'h8000_0000;
    localparam logic [31:0] LIM_POS  = 32'h7FFF_FFFF;
    localparam logic [31:0] LIM_DIST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        operation;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
    } spd_in_t;

    typedef struct packed {
        logic [31:0]        distance;
        logic signed [31:0] depth;
        logic [1:0]         status;
    } spd_out_t;

endpackage

[rtl/core/spd_mul.sv]
module spd_mul
    import spd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    input  logic                neg,
    output logic                done,
    output logic signed [127:0] prod
);

    logic [63:0]         ma_reg, ma_next;
    logic [63:0]         mb_reg, mb_next;
    logic                sgn_reg, sgn_next;
    logic signed [127:0] prod_reg, prod_next;
    logic [2:0]          step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [31:0]         opa, opb;
    logic [63:0]         pp;
    logic [127:0]        addend;

    always_comb
    begin
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        sgn_next  = sgn_reg;
        prod_next = prod_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        opa       = ma_reg[31:0];
        opb       = mb_reg[31:0];
        case (step_reg[1:0])
            2'd0:
            begin
                opa = ma_reg[31:0];
                opb = mb_reg[31:0];
            end
            2'd1:
            begin
                opa = ma_reg[31:0];
                opb = mb_reg[63:32];
            end
            2'd2:
            begin
                opa = ma_reg[63:32];
                opb = mb_reg[31:0];
            end
            default:
            begin
                opa = ma_reg[63:32];
                opb = mb_reg[63:32];
            end
        endcase
        pp = opa * opb;
        case (step_reg[1:0])
            2'd0:    addend = {64'd0, pp};
            2'd1:    addend = {32'd0, pp, 32'd0};
            2'd2:    addend = {32'd0, pp, 32'd0};
            default: addend = {pp, 64'd0};
        endcase
        if (start)
        begin
            ma_next   = a[63] ? 64'(-a) : 64'(a);
            mb_next   = b[63] ? 64'(-b) : 64'(b);
            sgn_next  = a[63] ^ b[63] ^ neg;
            prod_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg[2])
            begin
                prod_next = sgn_reg ? -prod_reg : prod_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                prod_next = prod_reg + $signed(addend);
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        sgn_reg  <= sgn_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

[rtl/core/spd_div.sv]
module spd_div
    import spd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [63:0]  den,
    input  logic [31:0]  limit,
    output logic         done,
    output logic [31:0]  quo
);

    logic [127:0] n_reg, n_next;
    logic [63:0]  d_reg, d_next;
    logic [31:0]  lim_reg, lim_next;
    logic [63:0]  r_reg, r_next;
    logic [31:0]  q_reg, q_next;
    logic         st_reg, st_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  res_reg, res_next;
    logic [63:0]  r_sh;
    logic         ge;

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        lim_next  = lim_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        r_sh      = {r_reg[62:0], n_reg[127]};
        ge        = (r_sh >= d_reg);
        if (start)
        begin
            n_next    = num;
            d_next    = den;
            lim_next  = limit;
            r_next    = '0;
            q_next    = '0;
            st_next   = 1'b0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next   = {n_reg[126:0], 1'b0};
            r_next   = ge ? r_sh - d_reg : r_sh;
            q_next   = {q_reg[30:0], ge};
            st_next  = st_reg | q_reg[31];
            cnt_next = cnt_reg + 7'd1;
            if (&cnt_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = (st_next || q_next > lim_reg) ? lim_reg : q_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        lim_reg <= lim_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        st_reg  <= st_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign quo  = res_reg;

endmodule

[rtl/core/spd_sqrt.sv]
module spd_sqrt
    import spd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] value,
    output logic         done,
    output logic [63:0]  root
);

    logic [127:0] v_reg, v_next;
    logic [67:0]  rem_reg, rem_next;
    logic [63:0]  root_reg, root_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         ge;

    always_comb
    begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[65:0], v_reg[127:126]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        if (start)
        begin
            v_next    = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next    = {v_reg[125:0], 2'b00};
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_reg[62:0], ge};
            cnt_next  = cnt_reg + 6'd1;
            if (&cnt_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/core/stereo_point_to_plane_distance_core.sv]
// Stereo match to plane distance. Each item (left x, left y, right x in 12.4 pixels) is
// reprojected to X, Y, Z; a load item stores the point and the third load forms the plane,
// a measure item returns one result with |n.p + d| / |n|, the depth Z and a status. One
// item is in work at a time: a 64 x 64 multiplier built from four 32 x 32 partial products,
// a 128-step restoring divider and a 64-step square root are shared under a sequencer. The
// divider is run once per coordinate and, for a measure, once more for the distance. An item
// whose disparity equals the offset skips the reprojection: a load is dropped and a measure
// returns the DEN status. A measure waits longer while the previous result has not been
// taken.
module stereo_point_to_plane_distance_core
    import spd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spd_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output spd_out_t             out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_MGO   = 4'd2;
    localparam logic [3:0] S_MWAIT = 4'd3;
    localparam logic [3:0] S_MEND  = 4'd4;
    localparam logic [3:0] S_DWAIT = 4'd5;
    localparam logic [3:0] S_SWAIT = 4'd6;
    localparam logic [3:0] S_BR    = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam logic [2:0] PH_REP = 3'd0;
    localparam logic [2:0] PH_CRS = 3'd1;
    localparam logic [2:0] PH_OFS = 3'd2;
    localparam logic [2:0] PH_SQR = 3'd3;
    localparam logic [2:0] PH_NUM = 3'd4;

    function automatic logic signed [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    logic signed [31:0]  offx_reg, offy_reg, focal_reg, base_reg, cx_reg;

    logic [3:0]          state_reg, state_next;
    logic [2:0]          phase_reg, phase_next;
    logic [1:0]          k_reg, k_next;
    logic [1:0]          j_reg, j_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                ov_reg, ov_next;
    logic signed [63:0]  nrm_reg [3];
    logic signed [63:0]  nrm_next [3];
    logic signed [63:0]  off_reg, off_next;
    logic [63:0]         norm_reg, norm_next;

    logic                meas_reg, meas_next;
    logic signed [63:0]  den_reg, den_next;
    logic signed [63:0]  px_reg, px_next;
    logic signed [63:0]  py_reg, py_next;
    logic signed [127:0] acc_reg, acc_next;
    logic signed [31:0]  xyz_reg [3];
    logic signed [31:0]  xyz_next [3];
    logic signed [31:0]  pts_reg [9];
    logic signed [31:0]  pts_next [9];
    logic [31:0]         rdist_reg, rdist_next;
    logic signed [31:0]  rdepth_reg, rdepth_next;
    logic [1:0]          rstat_reg, rstat_next;
    spd_out_t            out_reg, out_next;

    logic signed [63:0]  op_a, op_b;
    logic                op_neg;
    logic [1:0]          j_last;
    logic                mul_start, mul_done;
    logic signed [127:0] mul_prod;
    logic                div_start, div_done;
    logic [127:0]        div_num;
    logic [63:0]         div_den;
    logic [31:0]         div_lim;
    logic [31:0]         div_q;
    logic                sqrt_start, sqrt_done;
    logic [63:0]         sqrt_root;

    logic signed [63:0]  ux, uy, uz, vx, vy, vz;
    logic                rneg;
    logic [127:0]        acc_abs;
    logic signed [127:0] acc_sh, dw;
    logic                dw_fits;
    logic signed [16:0]  diff;
    logic [16:0]         dmag;
    logic signed [63:0]  disp;
    logic [1:0]          ce;
    logic [3:0]          pidx;

    assign ux = sx32(pts_reg[3]) - sx32(pts_reg[0]);
    assign uy = sx32(pts_reg[4]) - sx32(pts_reg[1]);
    assign uz = sx32(pts_reg[5]) - sx32(pts_reg[2]);
    assign vx = sx32(pts_reg[6]) - sx32(pts_reg[0]);
    assign vy = sx32(pts_reg[7]) - sx32(pts_reg[1]);
    assign vz = sx32(pts_reg[8]) - sx32(pts_reg[2]);

    // term operands per phase
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        j_last = 2'd0;
        case (phase_reg)
            PH_REP:
            begin
                case (k_reg)
                    2'd0:    op_a = px_reg;
                    2'd1:    op_a = py_reg;
                    default: op_a = sx32(focal_reg);
                endcase
                op_b   = sx32(base_reg);
                j_last = 2'd0;
            end
            PH_CRS:
            begin
                op_neg = j_reg[0];
                j_last = 2'd1;
                case (k_reg)
                    2'd0:
                    begin
                        op_a = j_reg[0] ? uz : uy;
                        op_b = j_reg[0] ? vy : vz;
                    end
                    2'd1:
                    begin
                        op_a = j_reg[0] ? ux : uz;
                        op_b = j_reg[0] ? vz : vx;
                    end
                    default:
                    begin
                        op_a = j_reg[0] ? uy : ux;
                        op_b = j_reg[0] ? vx : vy;
                    end
                endcase
            end
            PH_OFS:
            begin
                j_last = 2'd2;
                case (j_reg)
                    2'd0:
                    begin
                        op_a = nrm_reg[0];
                        op_b = sx32(pts_reg[0]);
                    end
                    2'd1:
                    begin
                        op_a = nrm_reg[1];
                        op_b = sx32(pts_reg[1]);
                    end
                    default:
                    begin
                        op_a = nrm_reg[2];
                        op_b = sx32(pts_reg[2]);
                    end
                endcase
            end
            PH_SQR:
            begin
                j_last = 2'd2;
                case (j_reg)
                    2'd0:    op_a = nrm_reg[0];
                    2'd1:    op_a = nrm_reg[1];
                    default: op_a = nrm_reg[2];
                endcase
                op_b = op_a;
            end
            PH_NUM:
            begin
                j_last = 2'd3;
                case (j_reg)
                    2'd0:
                    begin
                        op_a = nrm_reg[0];
                        op_b = sx32(xyz_reg[0]);
                    end
                    2'd1:
                    begin
                        op_a = nrm_reg[1];
                        op_b = sx32(xyz_reg[1]);
                    end
                    2'd2:
                    begin
                        op_a = nrm_reg[2];
                        op_b = sx32(xyz_reg[2]);
                    end
                    default:
                    begin
                        op_a = off_reg;
                        op_b = 64'sd1 <<< FRAC_BITS;
                    end
                endcase
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign rneg    = ~(op_a[63] ^ base_reg[31] ^ den_reg[63]);
    assign acc_abs = acc_reg[127] ? 128'(-acc_reg) : 128'(acc_reg);
    assign acc_sh  = (acc_reg + (acc_reg[127] ? $signed((128'd1 << FRAC_BITS) - 128'd1)
                                              : 128'sd0)) >>> FRAC_BITS;
    assign dw      = -acc_sh;
    assign dw_fits = (&dw[127:63]) | ~(|dw[127:63]);

    assign div_num = acc_abs;
    assign div_den = (phase_reg == PH_REP) ? (den_reg[63] ? 64'(-den_reg) : 64'(den_reg))
                                           : norm_reg;
    assign div_lim = (phase_reg == PH_REP) ? (rneg ? LIM_NEG : LIM_POS) : LIM_DIST;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg;
        nrm_next    = nrm_reg;
        off_next    = off_reg;
        norm_next   = norm_reg;
        meas_next   = meas_reg;
        den_next    = den_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        acc_next    = acc_reg;
        xyz_next    = xyz_reg;
        pts_next    = pts_reg;
        rdist_next  = rdist_reg;
        rdepth_next = rdepth_reg;
        rstat_next  = rstat_reg;
        out_next    = out_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        sqrt_start  = 1'b0;
        diff        = $signed({1'b0, in_data.left_x}) - $signed({1'b0, in_data.right_x});
        dmag        = diff[16] ? 17'(-diff) : 17'(diff);
        disp        = diff[16] ? -$signed({51'd0, dmag[16:4]}) : $signed({51'd0, dmag[16:4]});
        ce          = (cnt_reg == 2'd3) ? 2'd0 : cnt_reg;
        pidx        = 4'({2'b00, ce} * 4'd3);

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    meas_next  = (in_data.operation == OP_MEASURE);
                    den_next   = (disp <<< FRAC_BITS) - sx32(cx_reg);
                    px_next    = $signed({48'd0, in_data.left_x} << (FRAC_BITS - 4))
                                 + sx32(offx_reg);
                    py_next    = $signed({48'd0, in_data.left_y} << (FRAC_BITS - 4))
                                 + sx32(offy_reg);
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (den_reg == 64'sd0)
                begin
                    if (meas_reg)
                    begin
                        rdist_next  = '0;
                        rdepth_next = '0;
                        rstat_next  = STAT_DEN;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    phase_next = PH_REP;
                    k_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_MGO;
                end
            end
            S_MGO:
            begin
                mul_start  = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    acc_next = acc_reg + mul_prod;
                    if (j_reg == j_last)
                    begin
                        state_next = S_MEND;
                    end
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = S_MGO;
                    end
                end
            end
            S_MEND:
            begin
                case (phase_reg)
                    PH_REP, PH_NUM:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DWAIT;
                    end
                    PH_CRS:
                    begin
                        nrm_next[k_reg] = acc_sh[63:0];
                        acc_next        = '0;
                        j_next          = '0;
                        state_next      = S_MGO;
                        if (k_reg == 2'd2)
                        begin
                            phase_next = PH_OFS;
                            k_next     = '0;
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                    PH_OFS:
                    begin
                        if (dw_fits)
                        begin
                            off_next = dw[63:0];
                        end
                        else
                        begin
                            nrm_next[0] = '0;
                            nrm_next[1] = '0;
                            nrm_next[2] = '0;
                            off_next    = '0;
                        end
                        phase_next = PH_SQR;
                        acc_next   = '0;
                        j_next     = '0;
                        state_next = S_MGO;
                    end
                    PH_SQR:
                    begin
                        sqrt_start = 1'b1;
                        state_next = S_SWAIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    if (phase_reg == PH_REP)
                    begin
                        xyz_next[k_reg] = rneg ? 32'(~div_q + 32'd1) : div_q;
                        if (k_reg == 2'd2)
                        begin
                            state_next = S_BR;
                        end
                        else
                        begin
                            k_next     = k_reg + 2'd1;
                            j_next     = '0;
                            acc_next   = '0;
                            state_next = S_MGO;
                        end
                    end
                    else
                    begin
                        rdist_next  = div_q;
                        rdepth_next = xyz_reg[2];
                        rstat_next  = STAT_OK;
                        state_next  = S_EMIT;
                    end
                end
            end
            S_SWAIT:
            begin
                if (sqrt_done)
                begin
                    norm_next  = sqrt_root;
                    state_next = S_IDLE;
                end
            end
            S_BR:
            begin
                if (!meas_reg)
                begin
                    if (cnt_reg == 2'd3)
                    begin
                        nrm_next[0] = '0;
                        nrm_next[1] = '0;
                        nrm_next[2] = '0;
                        off_next    = '0;
                        norm_next   = '0;
                    end
                    pts_next[pidx]        = xyz_reg[0];
                    pts_next[pidx + 4'd1] = xyz_reg[1];
                    pts_next[pidx + 4'd2] = xyz_reg[2];
                    cnt_next              = ce + 2'd1;
                    if (ce == 2'd2)
                    begin
                        phase_next = PH_CRS;
                        k_next     = '0;
                        j_next     = '0;
                        acc_next   = '0;
                        state_next = S_MGO;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (cnt_reg != 2'd3 || norm_reg == 64'd0)
                begin
                    rdist_next  = '0;
                    rdepth_next = xyz_reg[2];
                    rstat_next  = STAT_PLANE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    phase_next = PH_NUM;
                    k_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_MGO;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    out_next.distance = rdist_reg;
                    out_next.depth    = rdepth_reg;
                    out_next.status   = rstat_reg;
                    ov_next           = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offx_reg   <= '0;
            offy_reg   <= '0;
            focal_reg  <= '0;
            base_reg   <= '0;
            cx_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_X: offx_reg  <= cfg_data;
                REG_OFFSET_Y: offy_reg  <= cfg_data;
                REG_FOCAL:    focal_reg <= cfg_data;
                REG_BASELINE: base_reg  <= cfg_data;
                REG_DISP_OFS: cx_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_REP;
            k_reg      <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
            nrm_reg[0] <= '0;
            nrm_reg[1] <= '0;
            nrm_reg[2] <= '0;
            off_reg    <= '0;
            norm_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            nrm_reg   <= nrm_next;
            off_reg   <= off_next;
            norm_reg  <= norm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg   <= meas_next;
        den_reg    <= den_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        acc_reg    <= acc_next;
        xyz_reg    <= xyz_next;
        pts_reg    <= pts_next;
        rdist_reg  <= rdist_next;
        rdepth_reg <= rdepth_next;
        rstat_reg  <= rstat_next;
        out_reg    <= out_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    spd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .neg   (op_neg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    spd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .limit (div_lim),
        .done  (div_done),
        .quo   (div_q)
    );

    spd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (acc_abs),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import spd_pkg::*;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 700;
    localparam logic [CFG_IDX_W-1:0] REG_LIST [5] =
        '{REG_OFFSET_X, REG_OFFSET_Y, REG_FOCAL, REG_BASELINE, REG_DISP_OFS};
    localparam logic signed [127:0] S64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] S64_MIN = -S64_MAX - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    spd_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    spd_out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    stereo_point_to_plane_distance_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    longint ofs_x_r = 0, ofs_y_r = 0, focal_r = 0, base_r = 0, disp_ofs_r = 0;
    logic signed [31:0] plane_pts [9];
    int unsigned pts_held = 0;
    longint plane_n [3] = '{0, 0, 0};
    longint plane_d = 0;

    spd_in_t pending_items [$];
    spd_out_t expected_results [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    function automatic void queue_item(spd_in_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void expect_result(spd_out_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [127:0] mag(longint v);
        logic [63:0] u;
        u = v;
        return v < 0 ? {64'b0, -u} : {64'b0, u};
    endfunction

    function automatic longint sat64(logic signed [127:0] v);
        if (v > S64_MAX)
            return S64_MAX[63:0];
        if (v < S64_MIN)
            return S64_MIN[63:0];
        return v[63:0];
    endfunction

    function automatic logic signed [31:0] reproject(longint v, longint d);
        logic neg;
        logic [127:0] q;
        neg = !(((v < 0) != (base_r < 0)) != (d < 0));
        q = (mag(v) * mag(base_r)) / mag(d);
        if (neg)
        begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF)
            q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic longint cross_term(longint a1, longint b1, longint a2, longint b2);
        logic signed [127:0] x1, y1, x2, y2;
        x1 = a1;
        y1 = b1;
        x2 = a2;
        y2 = b2;
        return sat64((x1 * y1 - x2 * y2) / 128'sd65536);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [63:0] root, rem, trial;
        root = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[61:0], v[2*i +: 2]};
            trial = {root[61:0], 2'b01};
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = {root[62:0], 1'b1};
            end
            else
                root = {root[62:0], 1'b0};
        end
        return root;
    endfunction

    task automatic form_plane();
        longint ux, uy, uz, vx, vy, vz;
        logic signed [127:0] s, dw, n0, n1, n2, p0, p1, p2;
        ux = longint'(plane_pts[3]) - plane_pts[0];
        uy = longint'(plane_pts[4]) - plane_pts[1];
        uz = longint'(plane_pts[5]) - plane_pts[2];
        vx = longint'(plane_pts[6]) - plane_pts[0];
        vy = longint'(plane_pts[7]) - plane_pts[1];
        vz = longint'(plane_pts[8]) - plane_pts[2];
        plane_n[0] = cross_term(uy, vz, uz, vy);
        plane_n[1] = cross_term(uz, vx, ux, vz);
        plane_n[2] = cross_term(ux, vy, uy, vx);
        n0 = plane_n[0];
        n1 = plane_n[1];
        n2 = plane_n[2];
        p0 = plane_pts[0];
        p1 = plane_pts[1];
        p2 = plane_pts[2];
        s = n0 * p0 + n1 * p1 + n2 * p2;
        dw = -(s / 128'sd65536);
        if (dw >= S64_MIN && dw <= S64_MAX)
            plane_d = dw[63:0];
        else
        begin
            plane_n = '{0, 0, 0};
            plane_d = 0;
        end
    endtask

    task automatic predict_item(spd_in_t it);
        longint diff, disp, den, px, py;
        logic signed [31:0] cx, cy, cz;
        logic [127:0] sumsq, absnum, q;
        logic signed [127:0] num, w0, w1, w2, wd, c0, c1, c2;
        logic [63:0] norm;
        spd_out_t r;
        diff = longint'(it.left_x) - longint'(it.right_x);
        disp = diff / 16;
        den = disp * (longint'(1) << FRAC) - disp_ofs_r;
        px = longint'(it.left_x) * (longint'(1) << (FRAC - 4)) + ofs_x_r;
        py = longint'(it.left_y) * (longint'(1) << (FRAC - 4)) + ofs_y_r;
        if (den == 0)
        begin
            if (it.operation == OP_MEASURE)
            begin
                r.distance = '0;
                r.depth = '0;
                r.status = STAT_DEN;
                expect_result(r);
            end
            return;
        end
        cx = reproject(px, den);
        cy = reproject(py, den);
        cz = reproject(focal_r, den);
        if (it.operation == OP_LOAD)
        begin
            if (pts_held >= 3)
            begin
                pts_held = 0;
                plane_n = '{0, 0, 0};
                plane_d = 0;
            end
            plane_pts[pts_held*3] = cx;
            plane_pts[pts_held*3+1] = cy;
            plane_pts[pts_held*3+2] = cz;
            pts_held++;
            if (pts_held == 3)
                form_plane();
            return;
        end
        sumsq = mag(plane_n[0]) * mag(plane_n[0]) + mag(plane_n[1]) * mag(plane_n[1])
              + mag(plane_n[2]) * mag(plane_n[2]);
        norm = floor_sqrt(sumsq);
        r.depth = cz;
        r.distance = '0;
        if (pts_held < 3 || norm == 0)
            r.status = STAT_PLANE;
        else
        begin
            w0 = plane_n[0];
            w1 = plane_n[1];
            w2 = plane_n[2];
            wd = plane_d;
            c0 = cx;
            c1 = cy;
            c2 = cz;
            num = w0 * c0 + w1 * c1 + w2 * c2 + wd * 128'sd65536;
            absnum = num < 0 ? -num : num;
            q = absnum / {64'b0, norm};
            r.distance = q > 128'hFFFF_FFFF ? LIM_DIST : q[31:0];
            r.status = STAT_OK;
        end
        expect_result(r);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                predict_item(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver, checker and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= $urandom_range(99) >= recv_stall_pct;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    spd_out_t e;
                    e = expected_results.pop_front();
                    if (out_data.distance !== e.distance || out_data.depth !== e.depth
                        || out_data.status !== e.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp dist %h depth %h st %0d, got %h %h %0d",
                                     e.distance, e.depth, e.status,
                                     out_data.distance, out_data.depth, out_data.status);
                    end
                end
            end
        end
    end

    function automatic spd_in_t make_item(logic op, int lx, int ly, int rx);
        spd_in_t it;
        it.operation = op;
        it.left_x = 16'(lx);
        it.left_y = 16'(ly);
        it.right_x = 16'(rx);
        return it;
    endfunction

    // plausible match with a positive disparity of 1 to 200 pixels where left x allows it, else random right x
    function automatic spd_in_t make_match(logic op);
        int lx, dx;
        lx = $urandom_range(65535);
        dx = $urandom_range(3200, 16);
        return make_item(op, lx, $urandom_range(65535),
                         lx >= dx ? lx - dx : $urandom_range(65535));
    endfunction

    task automatic write_config(logic [31:0] vals [5]);
        for (int i = 0; i < 5; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= REG_LIST[i];
            cfg_data <= vals[i];
            case (REG_LIST[i])
                REG_OFFSET_X: ofs_x_r = longint'(signed'(vals[i]));
                REG_OFFSET_Y: ofs_y_r = longint'(signed'(vals[i]));
                REG_FOCAL:    focal_r = longint'(signed'(vals[i]));
                REG_BASELINE: base_r = longint'(signed'(vals[i]));
                REG_DISP_OFS: disp_ofs_r = longint'(signed'(vals[i]));
                default: ;
            endcase
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                queue_item(make_item(1'($urandom_range(1)), $urandom_range(65535),
                                     $urandom_range(65535),
                                     $urandom_range(65535)));
                n++;
            end
            else
            begin
                int loads;
                loads = $urandom_range(99) < 85 ? 3 : $urandom_range(2, 1);
                for (int k = 0; k < loads; k++)
                    queue_item(make_match(OP_LOAD));
                for (int k = $urandom_range(4, 1); k > 0; k--)
                    queue_item(make_match(OP_MEASURE));
                n += loads + 2;
            end
        end
    endtask

    initial
    begin
        logic [31:0] cfg_sets [4][5];
        cfg_sets[0] = '{-32'sd320 <<< 16, -32'sd240 <<< 16, 32'd700 << 16,
                        -32'sd60 <<< 16, 32'd0};
        cfg_sets[1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'd5 << 16};
        cfg_sets[2] = '{32'd0, 32'd0, 32'd1, 32'h8000_0000, -32'sd196608 + 32'h1234};
        for (int i = 0; i < 5; i++)
            cfg_sets[3][i] = $urandom;
        cfg_sets[3][4] = $urandom_range(40, 0) << 16;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // default registers: zero coordinates give a degenerate plane
        queue_item(make_item(OP_MEASURE, 100, 100, 100));
        for (int k = 0; k < 3; k++)
            queue_item(make_match(OP_LOAD));
        queue_item(make_match(OP_MEASURE));
        wait_drained();

        write_config(cfg_sets[0]);
        queue_item(make_item(OP_LOAD, 500, 500, 500));
        queue_item(make_item(OP_MEASURE, 800, 300, 785));
        queue_item(make_item(OP_MEASURE, 65535, 65535, 0));
        for (int k = 0; k < 3; k++)
            queue_item(make_item(OP_LOAD, 4000, 3000, 3000));
        queue_item(make_item(OP_MEASURE, 4000, 3000, 3000));
        queue_item(make_item(OP_LOAD, 65535, 0, 0));
        queue_item(make_item(OP_LOAD, 0, 65535, 65535 - 16 * 700));
        queue_item(make_item(OP_LOAD, 30000, 20000, 29000));
        queue_item(make_item(OP_MEASURE, 65535, 65535, 0));
        queue_item(make_item(OP_MEASURE, 0, 0, 65535));
        queue_item(make_item(OP_MEASURE, 10000, 5000, 9000));
        queue_item(make_item(OP_MEASURE, 1000, 1000, 1000));
        queue_item(make_item(OP_LOAD, 20000, 10000, 19000));
        queue_item(make_item(OP_MEASURE, 20000, 10000, 18000));
        queue_item(make_item(OP_LOAD, 12000, 40000, 11000));
        queue_item(make_item(OP_LOAD, 50000, 2000, 48000));
        queue_item(make_item(OP_MEASURE, 33333, 22222, 32000));
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            if (p % 2 == 0)
                write_config(cfg_sets[p / 2]);
            case (p % 4)
                1: send_idle_pct = 86;
                2: recv_stall_pct = 86;
                3:
                begin
                    send_idle_pct = 29;
                    recv_stall_pct = 29;
                end
                default: ;
            endcase
            queue_random(72);
            wait_drained();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
